// ===== sv/bsfr_pkg.sv =====
// bsfr_pkg: types and constants for the byte-stuffed frame receiver
// no dependencies; used by bsfr_decode, bsfr_out_reg, the top level and the bench
package bsfr_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;

    localparam logic [15:0] MAX_RAW_RESET = 16'd264;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam logic [1:0]  KIND_DATA    = 2'd0;
    localparam logic [1:0]  KIND_END     = 2'd1;
    localparam logic [1:0]  KIND_NOSTART = 2'd2;
    localparam logic [1:0]  KIND_TRUNC   = 2'd3;

    localparam logic [1:0]  PH_WAIT = 2'd0;
    localparam logic [1:0]  PH_DATA = 2'd1;
    localparam logic [1:0]  PH_ESC  = 2'd2;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [1:0]  kind;
    } t_result;

endpackage

// ===== sv/bsfr_in_reg.sv =====
// bsfr_in_reg: input register for raw line bytes
// depends on nothing but the clock and reset of the top level
module bsfr_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/bsfr_decode.sv =====
// bsfr_decode: frame state and de-stuffing logic, one byte per advance
// depends on bsfr_pkg
module bsfr_decode
    import bsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_raw,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [1:0]  r_phase;
    logic [15:0] r_raw_count;
    logic [15:0] r_dec_count;
    logic [1:0]  n_phase;
    logic [15:0] n_raw_count;
    logic [15:0] n_dec_count;
    logic [15:0] raw_inc;
    logic [15:0] dec_inc;

    assign raw_inc = (r_raw_count < COUNT_MAX) ? r_raw_count + 16'd1 : r_raw_count;
    assign dec_inc = r_dec_count + 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_raw_count   = r_raw_count;
        n_dec_count   = r_dec_count;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (r_phase != PH_DATA && r_phase != PH_ESC) begin
            n_raw_count = '0;
            n_dec_count = '0;
            n_phase     = PH_WAIT;
            if (i_byte != FLAG_BYTE) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_NOSTART;
            end else if (i_max_raw <= 16'd1) begin
                // opening flag alone already reaches the limit
                o_res_valid = 1'b1;
                o_res.kind  = KIND_TRUNC;
            end else begin
                n_phase     = PH_DATA;
                n_raw_count = 16'd1;
            end
        end else if (r_phase == PH_DATA && i_byte == FLAG_BYTE) begin
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_END;
            o_res.frame_length = r_dec_count;
            n_phase            = PH_WAIT;
            n_raw_count        = '0;
            n_dec_count        = '0;
        end else if (raw_inc >= i_max_raw) begin
            // limit byte is dropped
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_TRUNC;
            o_res.frame_length = r_dec_count;
            n_phase            = PH_WAIT;
            n_raw_count        = '0;
            n_dec_count        = '0;
        end else if (r_phase == PH_ESC) begin
            o_res_valid     = 1'b1;
            o_res.kind      = KIND_DATA;
            o_res.data_byte = i_byte ^ ESC_XOR;
            n_phase         = PH_DATA;
            n_raw_count     = raw_inc;
            n_dec_count     = dec_inc;
        end else if (i_byte == ESC_BYTE) begin
            n_phase     = PH_ESC;
            n_raw_count = raw_inc;
        end else begin
            o_res_valid     = 1'b1;
            o_res.kind      = KIND_DATA;
            o_res.data_byte = i_byte;
            n_raw_count     = raw_inc;
            n_dec_count     = dec_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_raw_count <= '0;
            r_dec_count <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_raw_count <= n_raw_count;
            r_dec_count <= n_dec_count;
        end
    end

`ifndef NO_ASSERTIONS
    // counters are clear whenever no frame is open
    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_raw_count == 16'd0 && r_dec_count == 16'd0))
        else $error("counters not clear while waiting for flag");

    // every decoded byte used at least one raw byte beyond the opening flag
    a_dec_below_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_ESC) |-> (r_dec_count < r_raw_count))
        else $error("decoded count not below raw count");

    // a data result never carries a length
    a_data_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DATA) |-> (o_res.frame_length == 16'd0))
        else $error("data result with nonzero length");

    // an escape is always followed by data or a cut-off
    a_esc_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_ESC) |-> o_res_valid)
        else $error("escaped byte gave no result");
`endif

endmodule

// ===== sv/bsfr_out_reg.sv =====
// bsfr_out_reg: result register feeding the output stream
// depends on bsfr_pkg
module bsfr_out_reg
    import bsfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_advance,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // slot frees when empty or when the held result is taken this cycle
    assign o_advance = i_in_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/byte_stuffed_frame_receiver_top.sv =====
// byte_stuffed_frame_receiver_top: de-stuffing receiver for 0x7E-delimited frames
// depends on bsfr_pkg, bsfr_in_reg, bsfr_decode, bsfr_out_reg
//
// Takes one raw line byte per cycle and gives at most one result per byte:
// a decoded data byte, a frame end with the decoded length, a missing-start
// report, or a cut-off when the raw byte limit (cfg register, reset 264) is
// reached. A byte passes an input register and the decode logic into a
// result register, and a new byte is taken every cycle as long as the
// result register is empty or being drained; the frame state update is
// the loop that sets this rate. Write
// the limit only while no bytes are in flight.
module byte_stuffed_frame_receiver_top
    import bsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data     // max_raw_bytes
);

    logic [15:0] r_max_raw;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        advance;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_raw <= MAX_RAW_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_raw <= i_cfg_wr_data;
        end
    end

    bsfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    bsfr_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .i_max_raw   (r_max_raw),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bsfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_advance   (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {out_res.frame_length, out_res.data_byte};
    assign o_m_axis_tuser = out_res.kind;

endmodule

// ===== test/tb_byte_stuffed_frame_receiver_top.sv =====
// tb_byte_stuffed_frame_receiver_top: self-checking bench for the frame receiver
// depends on bsfr_pkg and byte_stuffed_frame_receiver_top; predicts every result
// from its own copy of the frame state and checks the result stream in order
`timescale 1ns / 1ps

module tb_byte_stuffed_frame_receiver_top;
    import bsfr_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          HOLD_CYCLES   = 120;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_BYTES  = 120;
    localparam logic [15:0] LIMIT_MIN     = 16'd3;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_wr_en     = 1'b0;
    logic [15:0] i_cfg_wr_data   = '0;

    // frame state mirror
    logic [1:0]  frm_phase = PH_WAIT;
    logic [15:0] raw_cnt   = '0;
    logic [15:0] dec_cnt   = '0;
    logic [15:0] raw_limit = MAX_RAW_RESET;

    t_result expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    byte_stuffed_frame_receiver_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void restart_frame();
        frm_phase = PH_WAIT;
        raw_cnt   = '0;
        dec_cnt   = '0;
    endfunction

    // advances the frame state by one raw byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] rx, output t_result res);
        bit has = 1'b1;
        res = '0;
        if (frm_phase != PH_DATA && frm_phase != PH_ESC) begin
            if (rx != FLAG_BYTE) begin
                restart_frame();
                res.kind = KIND_NOSTART;
            end else begin
                frm_phase = PH_DATA;
                raw_cnt   = 16'd1;
                dec_cnt   = '0;
                if (raw_cnt >= raw_limit) begin
                    restart_frame();
                    res.kind = KIND_TRUNC;
                end else begin
                    has = 1'b0;
                end
            end
        end else begin
            if (raw_cnt < COUNT_MAX) raw_cnt = raw_cnt + 16'd1;
            if (frm_phase == PH_DATA && rx == FLAG_BYTE) begin
                res.kind         = KIND_END;
                res.frame_length = dec_cnt;
                restart_frame();
            end else if (raw_cnt >= raw_limit) begin
                // the byte that hits the limit is dropped
                res.kind         = KIND_TRUNC;
                res.frame_length = dec_cnt;
                restart_frame();
            end else if (frm_phase == PH_ESC) begin
                frm_phase     = PH_DATA;
                dec_cnt       = dec_cnt + 16'd1;
                res.kind      = KIND_DATA;
                res.data_byte = rx ^ ESC_XOR;
            end else if (rx == ESC_BYTE) begin
                frm_phase = PH_ESC;
                has       = 1'b0;
            end else begin
                dec_cnt       = dec_cnt + 16'd1;
                res.kind      = KIND_DATA;
                res.data_byte = rx;
            end
        end
        return has;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %02h len %0d",
                    o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tdata[23:8]));
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser != want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                        o_m_axis_tuser, want.kind));
                if (o_m_axis_tdata[7:0] != want.data_byte)
                    report_mismatch($sformatf("data_byte %02h, expected %02h",
                        o_m_axis_tdata[7:0], want.data_byte));
                if (o_m_axis_tdata[23:8] != want.frame_length)
                    report_mismatch($sformatf("frame_length %0d, expected %0d",
                        o_m_axis_tdata[23:8], want.frame_length));
            end
        end
    end

    // one request on the input side; valid stays up until the caller idles or drains
    task automatic send_byte(input logic [7:0] rx);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (decode_byte(rx, res)) expected_results.push_back(res);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // bytes without a result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        raw_limit = value;
    endtask

    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(4))
            0:       return LIMIT_MIN;
            1:       return COUNT_MAX;
            2:       return MAX_RAW_RESET;
            3:       return 16'($urandom_range(4, 24));
            default: return 16'($urandom_range(LIMIT_MIN, COUNT_MAX));
        endcase
    endfunction

    task automatic send_random_sequence();
        int          n;
        logic [7:0]  pb;
        if ($urandom_range(9) == 0) begin
            // line noise between frames
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
        end else begin
            n = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
            send_byte(FLAG_BYTE);
            repeat (n) begin
                pb = pick_payload_byte();
                if (pb == FLAG_BYTE || pb == ESC_BYTE || $urandom_range(15) == 0) begin
                    send_byte(ESC_BYTE);
                    send_byte(pb ^ ESC_XOR);
                end else begin
                    send_byte(pb);
                end
            end
            // some frames lose their closing flag
            if ($urandom_range(9) != 0) send_byte(FLAG_BYTE);
        end
    endtask

    task automatic test_missing_start();
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_for_results();
    endtask

    task automatic test_frame_decode();
        // empty frame, then escaped flag, escaped escape and escape before a flag
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE ^ ESC_XOR);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE ^ ESC_XOR);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        wait_for_results();
    endtask

    task automatic test_raw_limit();
        write_limit(LIMIT_MIN);
        send_byte(FLAG_BYTE);
        send_byte(8'h41);
        send_byte(8'h42);
        // the byte that reaches the limit cuts the frame; a closing flag at the limit still ends the next one
        send_byte(FLAG_BYTE);
        send_byte(8'h41);
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        send_byte(ESC_BYTE);
        send_byte(FLAG_BYTE);
        write_limit(MAX_RAW_RESET);
    endtask

    task automatic test_limit_lowered_mid_frame();
        send_byte(FLAG_BYTE);
        send_byte(8'h11);
        send_byte(8'h22);
        write_limit(LIMIT_MIN);
        send_byte(8'h33);
        write_limit(MAX_RAW_RESET);
    endtask

    task automatic test_backpressure();
        int saved_idle;
        saved_idle = send_idle_pct;
        write_limit(16'd300);
        send_idle_pct = 0;
        hold_req = 1'b1;
        send_byte(FLAG_BYTE);
        repeat (60) send_byte(8'($urandom));
        send_byte(FLAG_BYTE);
        wait_for_results();
        send_idle_pct = saved_idle;
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            send_random_sequence();
            if ($urandom_range(7) == 0) write_limit(pick_limit());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 48;
        test_missing_start();
        test_frame_decode();
        test_raw_limit();
        test_limit_lowered_mid_frame();
        test_random_traffic(RANDOM_BYTES);

        send_idle_pct = 48;
        recv_idle_pct = 15;
        test_backpressure();
        test_random_traffic(RANDOM_BYTES);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_BYTES);

        wait_for_results();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== byte_stuffed_frame_receiver_top.f =====
sv/bsfr_pkg.sv
sv/bsfr_in_reg.sv
sv/bsfr_decode.sv
sv/bsfr_out_reg.sv
sv/byte_stuffed_frame_receiver_top.sv
test/tb_byte_stuffed_frame_receiver_top.sv
